@@ hdl/hphc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hphc_pkg
// Shared types and constants for the heater preheat and hysteresis control.
// ----------------------------------------------------------------------------
package hphc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET_AD      = 3'd0,
        CFG_PREHEAT_TIME_S = 3'd1,
        CFG_MIN_ON_S       = 3'd2,
        CFG_MIN_OFF_S      = 3'd3,
        CFG_PREHEAT_HOLD_S = 3'd4
    } t_cfg_idx;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 10;

    typedef struct packed {
        logic [9:0] target_ad;
        logic [9:0] preheat_time_s;
        logic [7:0] min_on_s;
        logic [7:0] min_off_s;
        logic [7:0] preheat_hold_s;
    } t_cfg;

    localparam logic [9:0] RstTargetAd     = 10'd512;
    localparam logic [9:0] RstPreheatTimeS = 10'd90;
    localparam logic [7:0] RstMinOnS       = 8'd10;
    localparam logic [7:0] RstMinOffS      = 8'd10;
    localparam logic [7:0] RstPreheatHoldS = 8'd30;

    typedef struct packed {
        logic [9:0] temp_ad;
        logic       second_tick;
    } t_in_item;

    typedef struct packed {
        logic [2:0] heat_level;
        logic [2:0] display_phase;
        logic       preheat_done;
    } t_out_item;

    // display phase codes
    localparam logic [2:0] PcInit       = 3'd0;
    localparam logic [2:0] PcPreheat    = 3'd1;
    localparam logic [2:0] PcHold       = 3'd2;
    localparam logic [2:0] PcHotWait    = 3'd3;
    localparam logic [2:0] PcColdStart  = 3'd4;
    localparam logic [2:0] PcEarlyStart = 3'd5;
    localparam logic [2:0] PcEarlyStop  = 3'd6;

    // heater levels
    localparam logic [2:0] LvlOff  = 3'd0;
    localparam logic [2:0] LvlOn   = 3'd1;
    localparam logic [2:0] LvlInit = 3'd5;

    // thresholds and limits
    localparam logic [9:0]  NearTarget   = 10'd6;
    localparam logic [10:0] BandHigh     = 11'd8;
    localparam logic [10:0] EarlyStartUp = 11'd3;
    localparam logic [10:0] EarlyStopUp  = 11'd6;
    localparam logic [7:0]  DutyPeriod   = 8'd20;
    localparam logic [16:0] Stage2Extra  = 17'd120;
    localparam logic [16:0] Stage3Extra  = 17'd180;
    localparam logic [16:0] Stage4Extra  = 17'd240;
    localparam logic [9:0]  Diff10       = 10'd10;
    localparam logic [9:0]  Diff20       = 10'd20;
    localparam logic [9:0]  Diff30       = 10'd30;
    localparam logic [9:0]  Diff60       = 10'd60;
    localparam logic [3:0]  ShareNone    = 4'd0;
    localparam logic [3:0]  ShareFour    = 4'd4;
    localparam logic [3:0]  ShareSix     = 4'd6;
    localparam logic [3:0]  ShareTen     = 4'd10;
    localparam logic [15:0] SecMax16     = 16'hFFFF;
    localparam logic [7:0]  SecMax8      = 8'hFF;

endpackage

@@ hdl/hphc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hphc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hphc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hphc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [hphc_pkg::CfgDataW-1:0]  i_cfg_data,
    output hphc_pkg::t_cfg                 o_cfg
);

    hphc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_ad      <= hphc_pkg::RstTargetAd;
            r_cfg.preheat_time_s <= hphc_pkg::RstPreheatTimeS;
            r_cfg.min_on_s       <= hphc_pkg::RstMinOnS;
            r_cfg.min_off_s      <= hphc_pkg::RstMinOffS;
            r_cfg.preheat_hold_s <= hphc_pkg::RstPreheatHoldS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hphc_pkg::CFG_TARGET_AD:      r_cfg.target_ad      <= i_cfg_data;
                hphc_pkg::CFG_PREHEAT_TIME_S: r_cfg.preheat_time_s <= i_cfg_data;
                hphc_pkg::CFG_MIN_ON_S:       r_cfg.min_on_s       <= i_cfg_data[7:0];
                hphc_pkg::CFG_MIN_OFF_S:      r_cfg.min_off_s      <= i_cfg_data[7:0];
                hphc_pkg::CFG_PREHEAT_HOLD_S: r_cfg.preheat_hold_s <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/hphc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hphc_ctrl
// Thermostat state and per-sample decision logic: preheat duty cycle,
// hold after preheat, and bang-bang regulation with minimum on/off times.
// ----------------------------------------------------------------------------
module hphc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  hphc_pkg::t_in_item  i_item,
    input  hphc_pkg::t_cfg      i_cfg,
    output hphc_pkg::t_out_item o_result
);

    typedef enum logic [1:0] {
        PH_INIT     = 2'd0,
        PH_PREHEAT  = 2'd1,
        PH_REGULATE = 2'd2
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [2:0]  r_level,     n_level;
    logic [15:0] r_pre_s,     n_pre_s;
    logic [7:0]  r_duty_s,    n_duty_s;
    logic [7:0]  r_hold_s,    n_hold_s;
    logic [7:0]  r_on_s,      n_on_s;
    logic [7:0]  r_off_s,     n_off_s;
    logic        r_heat_flag, n_heat_flag;
    logic [2:0]  r_code,      n_code;
    logic        w_done;

    // off share of the preheat duty cycle
    function automatic logic [3:0] off_share(input logic [15:0] ps,
                                             input logic [9:0] lim,
                                             input logic [9:0] diff);
        logic [16:0] ps_e;
        logic [16:0] lim_e;
        logic [3:0]  share;
        ps_e  = {1'b0, ps};
        lim_e = {7'b0, lim};
        if (ps_e < lim_e && diff > hphc_pkg::Diff30)
            share = hphc_pkg::ShareNone;
        else if (ps_e < lim_e + hphc_pkg::Stage2Extra && diff <= hphc_pkg::Diff30)
            share = hphc_pkg::ShareTen;
        else if (ps_e < lim_e + hphc_pkg::Stage3Extra && diff < hphc_pkg::Diff20)
            share = hphc_pkg::ShareSix;
        else if (ps_e < lim_e + hphc_pkg::Stage4Extra && diff < hphc_pkg::Diff10)
            share = hphc_pkg::ShareFour;
        else if (ps_e < lim_e + hphc_pkg::Stage3Extra && diff <= hphc_pkg::Diff60)
            share = hphc_pkg::ShareTen;
        else
            share = hphc_pkg::ShareNone;
        return share;
    endfunction

    logic [9:0]  w_diff;
    logic [10:0] w_t;
    logic [10:0] w_g;
    logic        w_tick;
    logic [15:0] w_pre_inc;
    logic [7:0]  w_duty_inc;
    logic [7:0]  w_duty_wrap;
    logic [3:0]  w_share;

    always_comb begin
        w_tick      = i_item.second_tick;
        w_t         = {1'b0, i_item.temp_ad};
        w_g         = {1'b0, i_cfg.target_ad};
        w_diff      = (i_cfg.target_ad > i_item.temp_ad) ?
                      (i_cfg.target_ad - i_item.temp_ad) : 10'd0;
        w_pre_inc   = (w_tick && r_pre_s != hphc_pkg::SecMax16) ? r_pre_s + 16'd1 : r_pre_s;
        w_duty_inc  = (w_tick && r_duty_s != hphc_pkg::SecMax8) ? r_duty_s + 8'd1 : r_duty_s;
        w_duty_wrap = (w_duty_inc > hphc_pkg::DutyPeriod) ? 8'd0 : w_duty_inc;
        w_share     = off_share(w_pre_inc, i_cfg.preheat_time_s, w_diff);

        n_phase     = r_phase;
        n_level     = r_level;
        n_pre_s     = r_pre_s;
        n_duty_s    = r_duty_s;
        n_hold_s    = r_hold_s;
        n_on_s      = r_on_s;
        n_off_s     = r_off_s;
        n_heat_flag = r_heat_flag;
        n_code      = r_code;
        w_done      = 1'b0;

        unique case (r_phase)
            PH_INIT: begin
                n_phase  = PH_PREHEAT;
                n_on_s   = 8'd0;
                n_off_s  = 8'd0;
                n_hold_s = 8'd0;
                n_pre_s  = 16'd0;
                n_level  = hphc_pkg::LvlInit;
            end
            PH_PREHEAT: begin
                if (w_diff < hphc_pkg::NearTarget) begin
                    n_hold_s    = i_cfg.preheat_hold_s;
                    n_heat_flag = 1'b0;
                    n_phase     = PH_REGULATE;
                    w_done      = 1'b1;
                    n_code      = hphc_pkg::PcHold;
                end else begin
                    n_pre_s  = w_pre_inc;
                    n_duty_s = w_duty_wrap;
                    n_level  = ({4'b0, w_duty_wrap} < {8'b0, w_share}) ?
                               hphc_pkg::LvlOff : hphc_pkg::LvlOn;
                    n_code   = hphc_pkg::PcPreheat;
                end
            end
            PH_REGULATE: begin
                if (w_t > w_g + hphc_pkg::BandHigh) begin
                    n_heat_flag = 1'b0;
                    n_code      = hphc_pkg::PcHotWait;
                end else if (w_t <= w_g) begin
                    n_heat_flag = 1'b1;
                    n_code      = hphc_pkg::PcColdStart;
                end else if (!r_heat_flag) begin
                    if (r_off_s > i_cfg.min_off_s && w_t <= w_g + hphc_pkg::EarlyStartUp) begin
                        n_heat_flag = 1'b1;
                        n_code      = hphc_pkg::PcEarlyStart;
                    end
                end else begin
                    if (r_on_s > i_cfg.min_on_s && w_t > w_g + hphc_pkg::EarlyStopUp) begin
                        n_heat_flag = 1'b0;
                        n_code      = hphc_pkg::PcEarlyStop;
                    end
                end
                n_level = {2'b0, n_heat_flag};
            end
            default: begin
                // unused phase value falls back to preheat
                n_phase = PH_PREHEAT;
            end
        endcase

        // forced-off hold after preheat
        if (n_hold_s != 8'd0) begin
            if (w_tick)
                n_hold_s = n_hold_s - 8'd1;
            n_level = hphc_pkg::LvlOff;
        end

        if (n_heat_flag) begin
            if (w_tick && n_on_s != hphc_pkg::SecMax8)
                n_on_s = n_on_s + 8'd1;
            n_off_s = 8'd0;
        end else begin
            if (w_tick && n_off_s != hphc_pkg::SecMax8)
                n_off_s = n_off_s + 8'd1;
            n_on_s = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INIT;
            r_level     <= 3'd0;
            r_pre_s     <= 16'd0;
            r_duty_s    <= 8'd0;
            r_hold_s    <= 8'd0;
            r_on_s      <= 8'd0;
            r_off_s     <= 8'd0;
            r_heat_flag <= 1'b0;
            r_code      <= hphc_pkg::PcInit;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_pre_s     <= n_pre_s;
            r_duty_s    <= n_duty_s;
            r_hold_s    <= n_hold_s;
            r_on_s      <= n_on_s;
            r_off_s     <= n_off_s;
            r_heat_flag <= n_heat_flag;
            r_code      <= n_code;
        end
    end

    assign o_result.heat_level    = n_level;
    assign o_result.display_phase = n_code;
    assign o_result.preheat_done  = w_done;

    a_done_enters_regulate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_done |=> r_phase == PH_REGULATE && !r_heat_flag)
        else $error("preheat done did not enter regulation with heater off");

    a_on_off_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_on_s != 8'd0 |-> r_off_s == 8'd0)
        else $error("on and off second counters both running");

    a_duty_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty_s <= hphc_pkg::DutyPeriod)
        else $error("duty second counter beyond its period");

endmodule

@@ hdl/heater_preheat_and_hysteresis_control.sv @@
`timescale 1ns / 1ps
// path: an input item is held in the input register, then passes the decision
//   logic into the result register once that register is free or being read
// throughput: one item per cycle while the output is read, one state update per item
// reset: synchronous active-low; state and configuration registers reload their
//   defaults, the next item is treated as the initialization item and answers level 5
// ----------------------------------------------------------------------------
// heater_preheat_and_hysteresis_control
// Heater controller: timed preheat duty cycle, hold after reaching target,
// then hysteresis regulation with minimum on and off times.
// ----------------------------------------------------------------------------
module heater_preheat_and_hysteresis_control (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hphc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [hphc_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hphc_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hphc_pkg::t_out_item            o_out_data
);

    hphc_pkg::t_cfg      w_cfg;
    hphc_pkg::t_out_item w_result;
    hphc_pkg::t_in_item  r_in_data;
    hphc_pkg::t_out_item r_out_data;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                w_move;
    logic                w_in_xfer;

    hphc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    hphc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_move),
        .i_item   (r_in_data),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // item leaves the input register when the result register is free or being read
    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer)
                r_in_valid <= 1'b1;
            else if (w_move)
                r_in_valid <= 1'b0;
            if (w_move)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer)
            r_in_data <= i_in_data;
        if (w_move)
            r_out_data <= w_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_move |=> r_in_valid && $stable(r_in_data))
        else $error("pending input item lost or changed");

    a_done_is_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.preheat_done |->
            o_out_data.display_phase == hphc_pkg::PcHold)
        else $error("preheat done without hold phase");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> o_out_valid)
        else $error("result register not filled after decision");

endmodule
